/* rtl/core/pfla_pkg.sv */
// Shared constants and types for the page free list allocator.
package pfla_pkg;

   localparam int MAX_PAGES    = 4096;
   localparam int INITIAL_FREE = 255;

   localparam int PAGE_W = 12;
   localparam int CNT_W  = PAGE_W + 1;

   localparam int INIT_LAST_INT = (INITIAL_FREE > MAX_PAGES - 1) ? MAX_PAGES - 1 : INITIAL_FREE;
   localparam logic [PAGE_W-1:0] INIT_LAST  = PAGE_W'(INIT_LAST_INT);
   localparam logic [CNT_W-1:0]  INIT_COUNT = CNT_W'(INIT_LAST_INT + 1);
   localparam logic [CNT_W-1:0]  MAX_COUNT  = CNT_W'(MAX_PAGES);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic STATUS_OK           = 1'b0;
   localparam logic STATUS_OUT_OF_PAGES = 1'b1;

   typedef logic [2:0] state_type;

   localparam state_type ST_INIT = 3'd0;
   localparam state_type ST_IDLE = 3'd1;
   localparam state_type ST_POP  = 3'd2;
   localparam state_type ST_GROW = 3'd3;

endpackage

/* rtl/core/pfla_ram.sv */
// Generic single write port RAM with one registered read port.
module pfla_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/page_free_list_allocator.sv */
// Top level of the linked free list page allocator.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_page_number
//   rsp      out        rsp_valid/rsp_stall  rsp_alloc_page, rsp_status
//
// Free: one link write, made only when the page is valid. Allocate from a
// non-empty list: one link read through the RAM's registered port, in ST_IDLE
// then ST_POP. Allocate that grows the store: one link write per new page.
// After reset a fill pass writes the INIT_LAST + 1 (256) initial links;
// no item is taken meanwhile.
// A result waits in an output register; a new item is taken once it drains.
module page_free_list_allocator
   import pfla_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [PAGE_W-1:0] req_page_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PAGE_W-1:0] rsp_alloc_page,
   output logic              rsp_status
);

   state_type         state_ff, state_in;
   logic [PAGE_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  page_count_ff, page_count_in;
   logic [CNT_W-1:0]  target_ff, target_in;
   logic [PAGE_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0] rsp_alloc_page_ff, rsp_alloc_page_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              mem_wr_en;
   logic [PAGE_W-1:0] mem_wr_addr;
   logic [PAGE_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [PAGE_W-1:0] mem_rd_data;

   logic              accept;
   logic              rsp_take;
   logic [CNT_W:0]    double_count;
   logic [CNT_W-1:0]  idx_next;
   logic              page_ok;

   pfla_ram #(
      .WIDTH(PAGE_W),
      .DEPTH(MAX_PAGES)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(free_head_ff),
      .rd_data(mem_rd_data)
   );

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign double_count = {page_count_ff, 1'b0};
   assign idx_next     = CNT_W'(idx_ff) + CNT_W'(1);
   assign page_ok      = (req_page_number != '0)
                         && ({1'b0, req_page_number} < page_count_ff);

   always_comb begin
      state_in          = state_ff;
      free_head_in      = free_head_ff;
      page_count_in     = page_count_ff;
      target_in         = target_ff;
      idx_in            = idx_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_take;
      rsp_alloc_page_in = rsp_alloc_page_ff;
      rsp_status_in     = rsp_status_ff;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = idx_ff;
      mem_wr_data       = free_head_ff;
      mem_rd_en         = 1'b0;

      case (state_ff)
         ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (idx_ff == '0) ? '0 : idx_ff - PAGE_W'(1);
            if (idx_ff == INIT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_next[PAGE_W-1:0];
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_FREE) begin
                  if (page_ok) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = req_page_number;
                     free_head_in = req_page_number;
                  end
                  rsp_valid_in      = 1'b1;
                  rsp_alloc_page_in = '0;
                  rsp_status_in     = STATUS_OK;
               end else if (free_head_ff != '0) begin
                  mem_rd_en = 1'b1;
                  state_in  = ST_POP;
               end else if (page_count_ff >= MAX_COUNT || page_count_ff == '0) begin
                  rsp_valid_in      = 1'b1;
                  rsp_alloc_page_in = '0;
                  rsp_status_in     = STATUS_OUT_OF_PAGES;
               end else begin
                  idx_in    = page_count_ff[PAGE_W-1:0];
                  target_in = (double_count > {1'b0, MAX_COUNT}) ? MAX_COUNT
                              : double_count[CNT_W-1:0];
                  state_in  = ST_GROW;
               end
            end
         end
         ST_POP: begin
            free_head_in      = mem_rd_data;
            rsp_valid_in      = 1'b1;
            rsp_alloc_page_in = free_head_ff;
            rsp_status_in     = STATUS_OK;
            state_in          = ST_IDLE;
         end
         ST_GROW: begin
            mem_wr_en = 1'b1;
            if (idx_next == target_ff) begin
               page_count_in     = target_ff;
               rsp_valid_in      = 1'b1;
               rsp_alloc_page_in = idx_ff;
               rsp_status_in     = STATUS_OK;
               state_in          = ST_IDLE;
            end else begin
               free_head_in = idx_ff;
               idx_in       = idx_next[PAGE_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         free_head_ff  <= INIT_LAST;
         page_count_ff <= INIT_COUNT;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         page_count_ff <= page_count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff         <= target_in;
      rsp_alloc_page_ff <= rsp_alloc_page_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_page = rsp_alloc_page_ff;
   assign rsp_status     = rsp_status_ff;

   head_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_GROW) |-> ({1'b0, free_head_ff} < page_count_ff))
      else $error("free head outside the page store");

   count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (page_count_ff >= $past(page_count_ff)) && (page_count_ff <= MAX_COUNT))
      else $error("page count shrank or passed the maximum");

   out_of_pages_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OUT_OF_PAGES)
      |-> (free_head_ff == '0 && page_count_ff == MAX_COUNT))
      else $error("out of pages reported while pages remain");

   no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW || state_ff == ST_POP || state_ff == ST_INIT) |-> req_stall)
      else $error("item taken while the sequencer is busy");

endmodule

/* tb/tb_page_free_list_allocator.sv */
// Self-checking testbench for the page free list allocator.
`timescale 1ns / 100ps

module tb_page_free_list_allocator;
   import pfla_pkg::*;

   localparam int QUIET_LIMIT = 20000;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              status;
   } answer_type;

   typedef struct packed {
      logic              kind;
      logic [PAGE_W-1:0] page;
      bit                typed;
      logic [PAGE_W-1:0] ans_page;
      logic              ans_status;
   } script_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_type = REQ_ALLOC;
   logic [PAGE_W-1:0] req_page_number = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PAGE_W-1:0] rsp_alloc_page;
   logic              rsp_status;

   // free list mirror
   logic [PAGE_W-1:0] link_mem [0:MAX_PAGES-1];
   logic [PAGE_W-1:0] list_head;
   logic [CNT_W-1:0]  store_pages;

   answer_type        pending_answers [$];
   logic [PAGE_W-1:0] held_pages [$];

   bit  idling = 1'b1;
   int  stall_left = 0;
   int  quiet_cycles = 0;
   int  errors = 0;
   int  alloc_ok_count = 0;
   int  out_of_pages_count = 0;
   int  free_count = 0;
   int  growth_count = 0;
   int  alloc_phase_sent = 0;

   script_row_type script [0:20] = '{
      '{REQ_ALLOC, 12'h000, 1'b1, INIT_LAST,            STATUS_OK},
      '{REQ_ALLOC, 12'hFFF, 1'b1, INIT_LAST - 12'd1,    STATUS_OK},
      '{REQ_FREE,  12'h000, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_FREE,  12'hFFF, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_FREE,  PAGE_W'(INIT_COUNT), 1'b1, 12'h000,  STATUS_OK},
      '{REQ_FREE,  INIT_LAST, 1'b1, 12'h000,            STATUS_OK},
      '{REQ_ALLOC, 12'h000, 1'b1, INIT_LAST,            STATUS_OK},
      '{REQ_FREE,  INIT_LAST, 1'b1, 12'h000,            STATUS_OK},
      '{REQ_FREE,  INIT_LAST, 1'b1, 12'h000,            STATUS_OK},
      '{REQ_ALLOC, 12'hAAA, 1'b0, 12'h000,              STATUS_OK},
      '{REQ_ALLOC, 12'h555, 1'b0, 12'h000,              STATUS_OK},
      '{REQ_FREE,  12'h001, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_FREE,  12'hAAA, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_FREE,  12'h055, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_ALLOC, 12'h000, 1'b0, 12'h000,              STATUS_OK},
      '{REQ_ALLOC, 12'hFFF, 1'b0, 12'h000,              STATUS_OK},
      '{REQ_FREE,  12'h0AA, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_ALLOC, 12'h000, 1'b0, 12'h000,              STATUS_OK},
      '{REQ_ALLOC, 12'h000, 1'b0, 12'h000,              STATUS_OK},
      '{REQ_FREE,  12'h800, 1'b1, 12'h000,              STATUS_OK},
      '{REQ_ALLOC, 12'h000, 1'b0, 12'h000,              STATUS_OK}
   };

   page_free_list_allocator uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_alloc_page  (rsp_alloc_page),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reset_free_list();
      for (int p = 0; p < MAX_PAGES; p++) begin
         link_mem[p] = (p >= 1 && p <= INIT_LAST_INT) ? PAGE_W'(p - 1) : '0;
      end
      list_head   = INIT_LAST;
      store_pages = INIT_COUNT;
   endfunction

   function automatic void next_answer(input logic kind, input logic [PAGE_W-1:0] pg,
                                       output answer_type ans);
      int target;
      ans.page   = '0;
      ans.status = STATUS_OK;
      if (kind == REQ_FREE) begin
         if (pg != '0 && {1'b0, pg} < store_pages) begin
            link_mem[pg] = list_head;
            list_head    = pg;
         end
      end else if (list_head == '0 && store_pages >= MAX_COUNT) begin
         ans.status = STATUS_OUT_OF_PAGES;
      end else begin
         if (list_head == '0) begin
            target = int'(store_pages) * 2;
            if (target > MAX_PAGES) target = MAX_PAGES;
            for (int n = int'(store_pages); n < target; n++) begin
               link_mem[n] = list_head;
               list_head   = PAGE_W'(n);
            end
            store_pages = CNT_W'(target);
            growth_count++;
         end
         ans.page  = list_head;
         list_head = link_mem[list_head];
      end
   endfunction

   task automatic send_request(input logic kind, input logic [PAGE_W-1:0] pg, input bit typed,
                               input logic [PAGE_W-1:0] t_page, input logic t_status);
      int         gap;
      answer_type ans;
      gap = idling ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_page_number <= pg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      next_answer(kind, pg, ans);
      if (kind == REQ_FREE) begin
         free_count++;
      end else if (ans.status == STATUS_OK) begin
         alloc_ok_count++;
         held_pages = {held_pages, ans.page};
      end else begin
         out_of_pages_count++;
      end
      if (typed) begin
         ans.page   = t_page;
         ans.status = t_status;
      end
      pending_answers = {pending_answers, ans};
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int mode);
      logic              kind;
      logic [PAGE_W-1:0] pg;
      int                idx;
      pg = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
      case (mode)
         0: begin
            kind = ($urandom_range(0, 99) < 85) ? REQ_ALLOC : REQ_FREE;
         end
         1: begin
            kind = ($urandom_range(0, 99) < 85) ? REQ_FREE : REQ_ALLOC;
         end
         default: begin
            kind = $urandom_range(0, 1) ? REQ_FREE : REQ_ALLOC;
            case ($urandom_range(0, 7))
               0: pg = '0;
               1: pg = PAGE_W'(store_pages - 1);
               2: pg = PAGE_W'(store_pages);
               3: pg = '1;
               default: ;
            endcase
         end
      endcase
      if (kind == REQ_FREE && mode != 2 && held_pages.size() != 0
          && $urandom_range(0, 9) != 0) begin
         idx = $urandom_range(0, held_pages.size() - 1);
         pg  = held_pages[idx];
         held_pages.delete(idx);
      end
      send_request(kind, pg, 1'b0, '0, STATUS_OK);
   endtask

   task automatic run_bursts(input int item_total);
      int mode;
      int len;
      int sent;
      sent = 0;
      while (sent < item_total) begin
         mode   = $urandom_range(0, 9);
         mode   = (mode < 4) ? 0 : (mode < 8) ? 1 : 2;
         len    = $urandom_range(20, 120);
         if (len > item_total - sent) len = item_total - sent;
         idling = ($urandom_range(0, 3) != 0);
         repeat (len) send_random(mode);
         sent += len;
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result: alloc_page %0d status %0d", rsp_alloc_page, rsp_status);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_alloc_page !== want.page) begin
               $error("alloc_page: expected %0d, actual %0d", want.page, rsp_alloc_page);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
         end
         stall_left = idling ? $urandom_range(0, 19) : 0;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset_free_list();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_request(script[i].kind, script[i].page, script[i].typed,
                      script[i].ans_page, script[i].ans_status);
      end
      hold_until_drained();

      run_bursts(1000);
      hold_until_drained();

      // lean on allocation for a while
      while (out_of_pages_count < 3 && alloc_phase_sent < 300) begin
         if (alloc_ok_count % 256 == 0) idling = ($urandom_range(0, 3) != 0);
         send_request(REQ_ALLOC, PAGE_W'($urandom_range(0, MAX_PAGES - 1)), 1'b0, '0,
                      STATUS_OK);
         alloc_phase_sent++;
      end
      run_bursts(300);

      hold_until_drained();
      repeat (10) @(negedge clock);

      $display("covered %0d allocations, %0d frees, %0d store growths",
               alloc_ok_count, free_count, growth_count);
      $display("out-of-pages answers %0d, final store size %0d pages",
               out_of_pages_count, store_pages);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pfla_pkg.sv
rtl/core/pfla_ram.sv
rtl/core/page_free_list_allocator.sv
tb/tb_page_free_list_allocator.sv
